/* rtl/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants for the bounded stack engine
// Holds the item types of both channels, the operation codes, the
// sequencer states and the store geometry.
// ----------------------------------------------------------------------------
package bse_pkg;

	// Store geometry
	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 9;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_EXTRACT = 2'd2,
		OP_CRUSH   = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		op_t                       op;
		logic signed [WORD_W-1:0]  push_value;
	} req_t;

	typedef struct packed {
		logic                      status;
		logic signed [WORD_W-1:0]  out_value;
		logic [CNT_W-1:0]          count;
		logic                      is_empty;
		logic                      is_full;
		logic signed [WORD_W-1:0]  top_value;
	} rsp_t;

	// Write request into the store
	typedef struct packed {
		logic                      en;
		logic [ADDR_W-1:0]         addr;
		logic [WORD_W-1:0]         data;
	} wr_req_t;

endpackage

/* rtl/bse_store.sv */
// ----------------------------------------------------------------------------
// bse_store: stack word store
// Synchronous memory with one write port and one read port; read data is
// registered and appears in the cycle after the read strobe, then holds.
// ----------------------------------------------------------------------------
module bse_store (
	input  logic                             clk,
	input  bse_pkg::wr_req_t                 wr,
	input  logic                             rd_en,
	input  logic [bse_pkg::ADDR_W-1:0]       rd_addr,
	output logic [bse_pkg::WORD_W-1:0]       rd_data
);

	logic [bse_pkg::WORD_W-1:0] mem [bse_pkg::DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port, held between strobes
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/bounded_stack_engine.sv */
// ----------------------------------------------------------------------------
// bounded_stack_engine: bounded LIFO stack of signed 32-bit words
// Push, pop, extract-below-top and crush-push with one result item per
// request item.
// ----------------------------------------------------------------------------
// Each item is accepted in ST_IDLE, which reads the entry under the top from
// the 256-word store, and finished in ST_EXEC, which uses that read data to
// build the result, update the count and top register and write the store
// back. The top word lives in a register, so only one store read is needed
// per item. A finished result waits in an output register while the next
// item is accepted; an item finishes only when that register is free. The
// capacity register (reset 256, values above 256 act as 256) is written
// through the cfg port, which is always ready. Store contents start
// undefined and need no clearing: only entries below the count are used.
// ----------------------------------------------------------------------------
module bounded_stack_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bse_pkg::req_t                 req,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bse_pkg::rsp_t                 rsp,
	// capacity write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bse_pkg::CNT_W-1:0]     cfg_data
);

	localparam int CNT_W  = bse_pkg::CNT_W;
	localparam int ADDR_W = bse_pkg::ADDR_W;
	localparam int WORD_W = bse_pkg::WORD_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(bse_pkg::DEPTH);

	bse_pkg::state_t  state_q, state_d;
	bse_pkg::req_t    req_q;
	bse_pkg::rsp_t    rsp_q, rsp_d;
	bse_pkg::wr_req_t wr;

	logic                     rsp_valid_q;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [WORD_W-1:0]        top_q, top_d;
	logic [CNT_W-1:0]         cap_q;
	logic [CNT_W-1:0]         eff_cap;
	logic [WORD_W-1:0]        rd_data;
	logic [CNT_W-1:0]         below_idx;
	logic                     accept;
	logic                     finish;

	// Handshakes
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != bse_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Entry under the top; wraps harmlessly when fewer than two are held
	assign below_idx = count_q - CNT_W'(2);

	// Clamp capacity to the store depth
	assign eff_cap = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;

	bse_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (below_idx[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and per-operation update
	always_comb begin
		logic              ok;
		logic              pop_first;
		logic [CNT_W-1:0]  c1;
		logic [WORD_W-1:0] val;

		state_d   = state_q;
		finish    = 1'b0;
		count_d   = count_q;
		top_d     = top_q;
		wr        = '0;
		ok        = 1'b0;
		pop_first = 1'b0;
		c1        = count_q;
		val       = '0;
		rsp_d     = rsp_q;

		case (state_q)
			bse_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bse_pkg::ST_EXEC;
				end
			end
			bse_pkg::ST_EXEC: begin
				case (req_q.op)
					bse_pkg::OP_PUSH: begin
						ok = (count_q < eff_cap);
						if (ok) begin
							wr.en   = 1'b1;
							wr.addr = count_q[ADDR_W-1:0];
							wr.data = req_q.push_value;
							count_d = count_q + CNT_W'(1);
							top_d   = req_q.push_value;
						end
					end
					bse_pkg::OP_POP: begin
						ok = (count_q != '0);
						if (ok) begin
							val     = top_q;
							count_d = count_q - CNT_W'(1);
							top_d   = rd_data;
						end
					end
					bse_pkg::OP_EXTRACT: begin
						ok = (count_q >= CNT_W'(2));
						if (ok) begin
							val     = rd_data;
							wr.en   = 1'b1;
							wr.addr = below_idx[ADDR_W-1:0];
							wr.data = top_q;
							count_d = count_q - CNT_W'(1);
						end else begin
							val = '1;
						end
					end
					bse_pkg::OP_CRUSH: begin
						pop_first = (count_q != '0) &&
							($signed(top_q) >= $signed(req_q.push_value));
						c1 = pop_first ? (count_q - CNT_W'(1)) : count_q;
						ok = (c1 < eff_cap);
						if (ok) begin
							wr.en   = 1'b1;
							wr.addr = c1[ADDR_W-1:0];
							wr.data = req_q.push_value;
							count_d = c1 + CNT_W'(1);
							top_d   = req_q.push_value;
						end else begin
							count_d = c1;
							top_d   = pop_first ? rd_data : top_q;
						end
					end
					default: begin
						ok = 1'b0;
					end
				endcase

				// Finish only when the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					finish = 1'b1;
					state_d = bse_pkg::ST_IDLE;
				end else begin
					wr.en   = 1'b0;
					count_d = count_q;
					top_d   = top_q;
				end

				rsp_d.status    = ok ? bse_pkg::ST_OK : bse_pkg::ST_FAIL;
				rsp_d.out_value = val;
				rsp_d.count     = count_d;
				rsp_d.is_empty  = (count_d == '0);
				rsp_d.is_full   = (count_d >= eff_cap);
				rsp_d.top_value = (count_d == '0) ? '0 : top_d;
			end
			default: begin
				state_d = bse_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers: count, capacity, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= DEPTH_C;
			rsp_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				count_q <= count_d;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, top word, result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (finish) begin
			top_q <= top_d;
			rsp_q <= rsp_d;
		end
	end

endmodule

/* tb/tb_bounded_stack_engine.sv */
// ----------------------------------------------------------------------------
// tb_bounded_stack_engine: self-checking bench for the bounded stack engine
// Drives push, pop, extract-below-top and crush-push items, mirrors the
// stack in a local model and compares each result item field by field.
// Capacity is rewritten between phases. Sender gaps and receiver stalls
// vary per phase, and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb_bounded_stack_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int DEPTH          = bse_pkg::DEPTH;
	localparam int CNT_W          = bse_pkg::CNT_W;
	localparam int WORD_W         = bse_pkg::WORD_W;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	bse_pkg::req_t    req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	bse_pkg::rsp_t    rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	// Local copy of the stack and its capacity
	logic signed [WORD_W-1:0] stack_words [DEPTH];
	int unsigned              held     = 0;
	int unsigned              cap_reg  = 256;
	bse_pkg::rsp_t            expected_q [$];

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	logic        hold_on        = 1'b0;
	int          mismatches     = 0;
	int          quiet_cycles   = 0;

	bounded_stack_engine dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	always #1 clk = ~clk;

	// Capacity values above the store size act as the store size
	function automatic int unsigned cap_limit();
		return (cap_reg > DEPTH) ? DEPTH : cap_reg;
	endfunction

	function automatic bit push_word(logic signed [WORD_W-1:0] w);
		if (held >= cap_limit() || held >= DEPTH)
			return 1'b0;
		stack_words[held] = w;
		held++;
		return 1'b1;
	endfunction

	// Apply one item to the local stack and build the result it causes
	function automatic bse_pkg::rsp_t stack_result(bse_pkg::req_t r);
		bse_pkg::rsp_t            res;
		bit                       ok;
		logic signed [WORD_W-1:0] val;
		res = '0;
		ok  = 1'b0;
		val = '0;
		case (r.op)
			bse_pkg::OP_PUSH: begin
				ok = push_word(r.push_value);
			end
			bse_pkg::OP_POP: begin
				if (held != 0) begin
					held--;
					val = stack_words[held];
					ok  = 1'b1;
				end
			end
			bse_pkg::OP_EXTRACT: begin
				if (held >= 2) begin
					val = stack_words[held-2];
					stack_words[held-2] = stack_words[held-1];
					held--;
					ok = 1'b1;
				end else begin
					val = '1;
				end
			end
			bse_pkg::OP_CRUSH: begin
				// signed compare: drop the top unless it is below the new word
				if (held != 0 && stack_words[held-1] >= r.push_value)
					held--;
				ok = push_word(r.push_value);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		res.status    = ok ? bse_pkg::ST_OK : bse_pkg::ST_FAIL;
		res.out_value = val;
		res.count     = held[CNT_W-1:0];
		res.is_empty  = (held == 0);
		res.is_full   = (held >= cap_limit());
		res.top_value = (held != 0) ? stack_words[held-1] : '0;
		return res;
	endfunction

	// Pick a word, often close to the current top to hit crush compares
	function automatic logic signed [WORD_W-1:0] pick_value();
		logic signed [WORD_W-1:0] top;
		top = (held != 0) ? stack_words[held-1] : '0;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4:          return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			5, 6:       return $urandom_range(8) - 4;
			7:          return top;
			8:          return $urandom_range(1) ? top + 1 : top - 1;
			default:    return top ^ 32'h8000_0000;
		endcase
	endfunction

	// Offer one item, with random gaps ahead of it, and record its result
	task automatic send_item(input bse_pkg::op_t op,
			input logic signed [WORD_W-1:0] value);
		bse_pkg::req_t item;
		item.op         = op;
		item.push_value = value;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_q.push_back(stack_result(item));
	endtask

	// Drain all results, then write the capacity register
	task automatic write_capacity(input int unsigned value);
		req_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[CNT_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = value & 32'h1FF;
	endtask

	// Random walk of the count: rise to the capacity, then fall to empty
	task automatic random_walk(input int n);
		bit           rising;
		bse_pkg::op_t op;
		rising = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (held >= cap_limit())
				rising = 1'b0;
			else if (held == 0)
				rising = 1'b1;
			else if ($urandom_range(49) == 0)
				rising = ~rising;
			if ($urandom_range(99) < (rising ? 70 : 30))
				op = ($urandom_range(2) == 0) ? bse_pkg::OP_CRUSH : bse_pkg::OP_PUSH;
			else
				op = ($urandom_range(1) == 0) ? bse_pkg::OP_EXTRACT : bse_pkg::OP_POP;
			send_item(op, pick_value());
		end
	endtask

	task automatic test_empty_and_order();
		send_item(bse_pkg::OP_POP, 0);
		send_item(bse_pkg::OP_EXTRACT, 0);
		send_item(bse_pkg::OP_PUSH, 32'sh7FFF_FFFF);
		send_item(bse_pkg::OP_EXTRACT, 0);
		send_item(bse_pkg::OP_PUSH, 32'sh8000_0000);
		send_item(bse_pkg::OP_PUSH, 0);
		send_item(bse_pkg::OP_PUSH, -1);
		send_item(bse_pkg::OP_EXTRACT, 32'h5A5A_A5A5);
		send_item(bse_pkg::OP_CRUSH, -1);
		send_item(bse_pkg::OP_CRUSH, 5);
		send_item(bse_pkg::OP_CRUSH, -7);
		send_item(bse_pkg::OP_CRUSH, 32'sh7FFF_FFFF);
		send_item(bse_pkg::OP_CRUSH, 32'sh8000_0000);
		for (int i = 0; i < 5; i++)
			send_item(bse_pkg::OP_POP, 32'hFFFF_FFFF);
		send_item(bse_pkg::OP_CRUSH, 42);
		send_item(bse_pkg::OP_POP, 0);
	endtask

	task automatic test_capacity_limits();
		for (int i = 0; i < 3; i++)
			send_item(bse_pkg::OP_PUSH, 10 * i);
		// zero capacity: always full, a crush pop stays done
		write_capacity(0);
		send_item(bse_pkg::OP_PUSH, 1);
		send_item(bse_pkg::OP_CRUSH, -100);
		send_item(bse_pkg::OP_POP, 0);
		// single entry
		write_capacity(1);
		send_item(bse_pkg::OP_PUSH, 3);
		send_item(bse_pkg::OP_CRUSH, 32'sh7FFF_FFFF);
		send_item(bse_pkg::OP_CRUSH, 32'sh8000_0000);
		send_item(bse_pkg::OP_POP, 0);
		send_item(bse_pkg::OP_PUSH, 77);
		send_item(bse_pkg::OP_PUSH, 78);
		// lower the capacity below the count
		write_capacity(5);
		for (int i = 0; i < 5; i++)
			send_item(bse_pkg::OP_PUSH, pick_value());
		write_capacity(2);
		send_item(bse_pkg::OP_PUSH, 9);
		send_item(bse_pkg::OP_EXTRACT, 0);
		send_item(bse_pkg::OP_POP, 0);
		// above the store size: fill every entry
		write_capacity(511);
		while (held < DEPTH)
			send_item(bse_pkg::OP_PUSH, pick_value());
		send_item(bse_pkg::OP_PUSH, 1);
		send_item(bse_pkg::OP_CRUSH, 32'sh8000_0000);
		send_item(bse_pkg::OP_EXTRACT, 0);
		send_item(bse_pkg::OP_POP, 0);
	endtask

	task automatic test_full_backpressure();
		write_capacity(256);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		random_walk(40);
	endtask

	task automatic test_random_walks();
		int unsigned caps [8] = '{256, 3, 1, 511, 40, 2, 128, 9};
		int unsigned src_pcts [4]  = '{0, 49, 0, 11};
		int unsigned sink_pcts [4] = '{0, 0, 49, 11};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct   = src_pcts[p];
			sink_stall_pct = sink_pcts[p];
			for (int s = 0; s < 2; s++) begin
				write_capacity(caps[2*p+s]);
				random_walk(155);
			end
		end
	endtask

	// Receiver stalls: random, or held high during the long hold
	always @(posedge clk)
		rsp_stall <= hold_on || ($urandom_range(99) < sink_stall_pct);

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		bse_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, actual %p", $time, rsp);
			end else begin
				want = expected_q.pop_front();
				check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
				check_field("out_value", want.out_value, rsp.out_value);
				check_field("count", WORD_W'(want.count), WORD_W'(rsp.count));
				check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp.is_empty));
				check_field("is_full", WORD_W'(want.is_full), WORD_W'(rsp.is_full));
				check_field("top_value", want.top_value, rsp.top_value);
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_order();
		src_idle_pct   = 11;
		sink_stall_pct = 11;
		test_capacity_limits();
		test_full_backpressure();
		test_random_walks();
		// hold the request line low and let results drain
		req_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
